[rtl/core/jfd_pkg.sv]
// Shared types and constants for the JPEG frame deframer.
// Used by jfd_parser and jpeg_frame_deframer_core; no dependencies.
`timescale 1ns / 1ps

package jfd_pkg;

    // Parser phase codes, as reported on the phase output.
    localparam logic [1:0] PH_HEADER  = 2'd0;
    localparam logic [1:0] PH_PAYLOAD = 2'd1;
    localparam logic [1:0] PH_FOOTER  = 2'd2;
    localparam logic [1:0] PH_FAILED  = 2'd3;

    // Frame delimiters: "JPGS" opens a frame, "JPGE" closes it.
    localparam logic [31:0] START_MAGIC = 32'h4A50_4753;
    localparam logic [31:0] END_MAGIC   = 32'h4A50_4745;

    // Header is magic plus a 32-bit length; footer is magic only.
    localparam int HDR_BYTES = 8;
    localparam int FTR_BYTES = 4;

    // Per-beat status from the parser, valid for the beat it takes.
    typedef struct packed {
        logic       frame_done;
        logic [1:0] phase;
    } t_parse_status;

endpackage

[rtl/core/jfd_image_ram.sv]
// Two-bank image store: one write port and one registered read port.
// Standalone; instantiated by jpeg_frame_deframer_core.
`timescale 1ns / 1ps

module jfd_image_ram #(
    parameter int ADDR_W = 16
) (
    input  logic              i_clk,
    input  logic              i_wr_en,
    input  logic [ADDR_W-1:0] i_wr_addr,
    input  logic [7:0]        i_wr_data,
    input  logic              i_rd_en,
    input  logic [ADDR_W-1:0] i_rd_addr,
    output logic [7:0]        o_rd_data
);

    logic [7:0] r_mem [2**ADDR_W];
    logic [7:0] r_rd_data;

    // Payload bytes land in the active bank.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Read data is held until the next enabled read.
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

[rtl/core/jfd_parser.sv]
// Frame parser: header, payload and footer tracking, bank selection.
// Depends on jfd_pkg; drives the write port of jfd_image_ram.
`timescale 1ns / 1ps

module jfd_parser #(
    parameter int BANK_BYTES = 32768,
    parameter int ADDR_W     = 16,
    parameter int LEN_W      = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_take,
    input  logic [7:0]            i_byte,
    output logic                  o_wr_en,
    output logic [ADDR_W-1:0]     o_wr_addr,
    output logic [7:0]            o_wr_data,
    output logic                  o_bank,
    output logic [LEN_W-1:0]      o_latest_len,
    output jfd_pkg::t_parse_status o_status
);

    localparam int OFS_W = ADDR_W - 1;

    logic [1:0]       r_phase,    n_phase;
    logic [LEN_W-1:0] r_cnt,      n_cnt;
    logic [55:0]      r_shift,    n_shift;
    logic [LEN_W-1:0] r_exp_len,  n_exp_len;
    logic [LEN_W-1:0] r_last_len, n_last_len;
    logic             r_bank,     n_bank;
    logic             done;

    logic [63:0]      shift_in;
    logic [LEN_W-1:0] cnt_inc;

    assign shift_in = {r_shift, i_byte};
    assign cnt_inc  = r_cnt + LEN_W'(1);

    // Next-state logic for one stream beat.
    always_comb begin
        n_phase    = r_phase;
        n_cnt      = r_cnt;
        n_shift    = r_shift;
        n_exp_len  = r_exp_len;
        n_last_len = r_last_len;
        n_bank     = r_bank;
        done       = 1'b0;
        if (i_take) begin
            case (r_phase)
                jfd_pkg::PH_HEADER: begin
                    n_shift = shift_in[55:0];
                    n_cnt   = cnt_inc;
                    if (r_cnt == LEN_W'(jfd_pkg::HDR_BYTES - 1)) begin
                        n_cnt   = '0;
                        n_shift = '0;
                        if (shift_in[63:32] != jfd_pkg::START_MAGIC ||
                            shift_in[31:0] > 32'(BANK_BYTES)) begin
                            n_phase = jfd_pkg::PH_FAILED;
                        end else begin
                            n_exp_len = shift_in[LEN_W-1:0];
                            n_phase   = (shift_in[31:0] == 32'd0) ?
                                        jfd_pkg::PH_FOOTER : jfd_pkg::PH_PAYLOAD;
                        end
                    end
                end
                jfd_pkg::PH_PAYLOAD: begin
                    n_cnt = cnt_inc;
                    if (cnt_inc == r_exp_len) begin
                        n_cnt   = '0;
                        n_phase = jfd_pkg::PH_FOOTER;
                    end
                end
                jfd_pkg::PH_FOOTER: begin
                    n_shift = {24'd0, shift_in[31:0]};
                    n_cnt   = cnt_inc;
                    if (r_cnt == LEN_W'(jfd_pkg::FTR_BYTES - 1)) begin
                        n_cnt   = '0;
                        n_shift = '0;
                        if (shift_in[31:0] != jfd_pkg::END_MAGIC) begin
                            n_phase = jfd_pkg::PH_FAILED;
                        end else begin
                            n_bank     = ~r_bank;
                            n_last_len = r_exp_len;
                            done       = 1'b1;
                            n_phase    = jfd_pkg::PH_HEADER;
                        end
                    end
                end
                default: begin
                    // Failed phase ignores stream bytes until reset.
                end
            endcase
        end
    end

    // Parser state registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= jfd_pkg::PH_HEADER;
            r_cnt      <= '0;
            r_shift    <= '0;
            r_exp_len  <= '0;
            r_last_len <= '0;
            r_bank     <= 1'b0;
        end else begin
            r_phase    <= n_phase;
            r_cnt      <= n_cnt;
            r_shift    <= n_shift;
            r_exp_len  <= n_exp_len;
            r_last_len <= n_last_len;
            r_bank     <= n_bank;
        end
    end

    // Payload write into the active bank, offset by the byte count.
    assign o_wr_en   = i_take && (r_phase == jfd_pkg::PH_PAYLOAD);
    assign o_wr_addr = {r_bank, r_cnt[OFS_W-1:0]};
    assign o_wr_data = i_byte;

    assign o_bank              = r_bank;
    assign o_latest_len        = n_last_len;
    assign o_status.frame_done = done;
    assign o_status.phase      = n_phase;

endmodule

[rtl/core/jpeg_frame_deframer_core.sv]
// JPEG frame deframer top level: parser, two-bank image store, output stages.
// Depends on jfd_pkg, jfd_parser and jfd_image_ram.
//
// Usage: each input beat (i_in_valid, o_in_stall) is either a stream byte
// (i_mode = 0, i_data_byte) or a read of the latest complete image
// (i_mode = 1, i_read_index). Frames are "JPGS", a 32-bit big-endian
// length, the payload and "JPGE". Payload bytes go into the active bank of
// the store, one write per beat; a good footer swaps banks and pulses
// o_frame_done. A bad magic, a length above BANK_BYTES or a bad footer
// enters a failed phase that only reset leaves; reads still work there.
// Every input beat yields one output beat (o_out_valid, i_out_stall).
// Throughput is one beat per cycle while the receiver does not stall; an
// accepted beat passes the registered read port of the store and then the
// output register. When the receiver stalls, the output register holds,
// one more beat is taken into the read stage if it is empty, and then
// o_in_stall rises. Synchronous reset empties both stages and returns the
// parser to the header phase with no image; the store is not cleared and
// needs no clearing pass, so the block takes beats right after reset.
`timescale 1ns / 1ps

module jpeg_frame_deframer_core #(
    parameter int BANK_BYTES = 32768
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic        i_mode,
    input  logic [7:0]  i_data_byte,
    input  logic [14:0] i_read_index,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [7:0]  o_read_byte,
    output logic [15:0] o_image_length,
    output logic        o_frame_done,
    output logic        o_frame_error,
    output logic [1:0]  o_phase
);

    localparam int OFS_W  = $clog2(BANK_BYTES);
    localparam int ADDR_W = OFS_W + 1;
    localparam int LEN_W  = $clog2(BANK_BYTES + 1);

    logic                   in_fire;
    logic                   s1_adv;
    logic                   wr_en;
    logic [ADDR_W-1:0]      wr_addr;
    logic [7:0]             wr_data;
    logic                   bank;
    logic [LEN_W-1:0]       latest_len;
    jfd_pkg::t_parse_status status;
    logic                   rd_hit;
    logic [ADDR_W-1:0]      rd_addr;
    logic [7:0]             rd_data;
    logic [31:0]            idx_ext;
    logic [31:0]            len_ext;
    logic [15:0]            len_sat;

    // Read stage registers (alongside the store's read register).
    logic                   r_s1_valid;
    logic                   r_s1_hit;
    logic [15:0]            r_s1_len;
    jfd_pkg::t_parse_status r_s1_status;

    // Output register.
    logic                   r_s2_valid;
    logic [7:0]             r_s2_byte;
    logic [15:0]            r_s2_len;
    jfd_pkg::t_parse_status r_s2_status;

    // Handshake: the read stage moves on whenever the output register is free.
    assign s1_adv     = !r_s2_valid || !i_out_stall;
    assign o_in_stall = r_s1_valid && !s1_adv;
    assign in_fire    = i_in_valid && !o_in_stall;

    jfd_parser #(
        .BANK_BYTES (BANK_BYTES),
        .ADDR_W     (ADDR_W),
        .LEN_W      (LEN_W)
    ) u_parser (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_take       (in_fire && !i_mode),
        .i_byte       (i_data_byte),
        .o_wr_en      (wr_en),
        .o_wr_addr    (wr_addr),
        .o_wr_data    (wr_data),
        .o_bank       (bank),
        .o_latest_len (latest_len),
        .o_status     (status)
    );

    // Reads hit the bank that holds the latest complete image.
    assign idx_ext = 32'(i_read_index);
    assign len_ext = 32'(latest_len);
    assign rd_hit  = i_mode && (idx_ext < len_ext);
    assign rd_addr = {~bank, idx_ext[OFS_W-1:0]};
    assign len_sat = (len_ext > 32'h0000_FFFF) ? 16'hFFFF : len_ext[15:0];

    jfd_image_ram #(
        .ADDR_W (ADDR_W)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (in_fire),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    // Read stage: sideband travels with the store's read data.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (in_fire) begin
            r_s1_valid <= 1'b1;
        end else if (s1_adv) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_s1_hit    <= rd_hit;
            r_s1_len    <= len_sat;
            r_s1_status <= status;
        end
    end

    // Output register: holds while the receiver stalls.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else if (s1_adv) begin
            r_s2_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv && r_s1_valid) begin
            r_s2_byte   <= r_s1_hit ? rd_data : 8'd0;
            r_s2_len    <= r_s1_len;
            r_s2_status <= r_s1_status;
        end
    end

    assign o_out_valid    = r_s2_valid;
    assign o_read_byte    = r_s2_byte;
    assign o_image_length = r_s2_len;
    assign o_frame_done   = r_s2_status.frame_done;
    assign o_phase        = r_s2_status.phase;
    assign o_frame_error  = (r_s2_status.phase == jfd_pkg::PH_FAILED);

endmodule
